// ===== src/aac_audio_specific_config_parser_macros.svh =====
// ----------------------------------------------------------------------------
// aac_audio_specific_config_parser_macros
// assertion macros for the audio specific config parser
// ----------------------------------------------------------------------------
`ifndef AAC_AUDIO_SPECIFIC_CONFIG_PARSER_MACROS_SVH
`define AAC_AUDIO_SPECIFIC_CONFIG_PARSER_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, sampled on clk, quiet during reset
`define AACASC_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define AACASC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define AACASC_ASSERT_IMPLIES(lbl, ante, cons, msg)
`define AACASC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== src/aacasc_pkg.sv =====
// ----------------------------------------------------------------------------
// aacasc_pkg
// types, constants and tables shared by the audio specific config parser
// ----------------------------------------------------------------------------
package aacasc_pkg;

    localparam int MAX_CONFIG_BYTES = 16;
    localparam int ADDR_W  = $clog2(MAX_CONFIG_BYTES);
    localparam int COUNT_W = $clog2(MAX_CONFIG_BYTES + 1);
    localparam int POS_W   = COUNT_W + 3;
    localparam int LEN_W   = 5;
    localparam int ACC_W   = 24;

    localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(MAX_CONFIG_BYTES);

    localparam logic [10:0] SYNC_SBR   = 11'h2b7;
    localparam logic [10:0] SYNC_PS    = 11'h548;
    localparam logic [4:0]  AOT_SBR    = 5'd5;
    localparam logic [4:0]  AOT_PS     = 5'd29;
    localparam logic [3:0]  IDX_ESCAPE = 4'hF;
    localparam logic [3:0]  NUM_RATES  = 4'd13;
    localparam logic [POS_W-1:0] SYNC_MIN_BITS = POS_W'(16);
    localparam logic [POS_W-1:0] PS_MIN_BITS   = POS_W'(12);

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_TRUNCATED  = 3'd1;
    localparam logic [2:0] ST_UNSUP_TYPE = 3'd2;
    localparam logic [2:0] ST_BAD_FREQ   = 3'd3;
    localparam logic [2:0] ST_BAD_CHAN   = 3'd4;

    localparam logic [3:0] LAYOUT_MONO   = 4'd1;
    localparam logic [3:0] LAYOUT_STEREO = 4'd2;
    localparam logic [3:0] LAYOUT_UNSUP  = 4'd8;
    localparam logic [3:0] CHAN_CFG_MAX  = 4'd8;

    typedef struct packed {
        logic [7:0] config_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [4:0]  object_type;
        logic [16:0] sample_rate;
        logic [23:0] extension_rate;
        logic        sbr_signalled;
        logic        ps_signalled;
        logic [3:0]  channel_layout;
    } out_item_t;

    typedef enum logic [4:0] {
        S_LOAD,
        S_START,
        S_CORE_TYPE,
        S_RATE_IDX,
        S_CHAN_CFG,
        S_EXT_IDX,
        S_EXT_ESC,
        S_CORE_TYPE2,
        S_CHECK_TYPE,
        S_GA_FLEN,
        S_GA_DEP,
        S_GA_DELAY,
        S_GA_EXT,
        S_GA_EXT3,
        S_SYNC_CHECK,
        S_SYNC_WORD,
        S_SYNC_TYPE,
        S_SBR_FLAG,
        S_SYNC_IDX,
        S_SYNC_ESC,
        S_PS_CHECK,
        S_PS_WORD,
        S_PS_FLAG,
        S_EVAL,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic             start;
        logic             clear_count;
        logic             go;
        logic [LEN_W-1:0] len;
    } rd_cmd_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [ACC_W-1:0] value;
        logic [POS_W-1:0] bits_left;
    } rd_stat_t;

    function automatic logic [16:0] rate_hz(input logic [3:0] idx);
        logic [16:0] hz;
        case (idx)
            4'd0:    hz = 17'd96000;
            4'd1:    hz = 17'd88200;
            4'd2:    hz = 17'd64000;
            4'd3:    hz = 17'd48000;
            4'd4:    hz = 17'd44100;
            4'd5:    hz = 17'd32000;
            4'd6:    hz = 17'd24000;
            4'd7:    hz = 17'd22050;
            4'd8:    hz = 17'd16000;
            4'd9:    hz = 17'd12000;
            4'd10:   hz = 17'd11025;
            4'd11:   hz = 17'd8000;
            4'd12:   hz = 17'd7350;
            default: hz = 17'd0;
        endcase
        return hz;
    endfunction

    // bits read by each field state, zero for states that read nothing
    function automatic logic [LEN_W-1:0] field_len(input state_t s);
        logic [LEN_W-1:0] n;
        case (s)
            S_CORE_TYPE, S_CORE_TYPE2, S_SYNC_TYPE:       n = LEN_W'(5);
            S_RATE_IDX, S_CHAN_CFG, S_EXT_IDX, S_SYNC_IDX: n = LEN_W'(4);
            S_EXT_ESC, S_SYNC_ESC:                         n = LEN_W'(24);
            S_GA_DELAY:                                    n = LEN_W'(14);
            S_SYNC_WORD, S_PS_WORD:                        n = LEN_W'(11);
            S_GA_FLEN, S_GA_DEP, S_GA_EXT, S_GA_EXT3,
            S_SBR_FLAG, S_PS_FLAG:                         n = LEN_W'(1);
            default:                                       n = LEN_W'(0);
        endcase
        return n;
    endfunction

endpackage

// ===== src/aac_audio_specific_config_parser.sv =====
// bytes are taken one per cycle while byte_stall is low (the parser is loading); the last byte starts a parse
// the parse reads one bit per cycle through the serial bit reader, field by field
// the result sits in an output register, and the next config loads while it waits
// reset (rst_n low, asynchronous) empties the byte store count and the output register
// ----------------------------------------------------------------------------
// aac_audio_specific_config_parser
// parses one aac audio specific config into core and extension parameters
// ----------------------------------------------------------------------------
`include "aac_audio_specific_config_parser_macros.svh"

module aac_audio_specific_config_parser
    import aacasc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      byte_valid,
    output logic      byte_stall,
    input  in_item_t  byte_data,
    output logic      result_valid,
    input  logic      result_stall,
    output out_item_t result_data
);

    rd_cmd_t   cmd;
    rd_stat_t  stat;
    logic      byte_accept;
    logic      load;
    logic      out_free;
    out_item_t result;
    logic      result_valid_reg, result_valid_next;
    out_item_t result_data_reg;
    logic      res_ok;
    logic      res_err;
    logic      err_layout;
    logic      err_clear;
    logic      type_ok;
    logic      last_in;

    assign byte_accept = byte_valid && !byte_stall;
    assign out_free    = !result_valid_reg || !result_stall;

    aacasc_bit_reader u_reader
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (byte_accept),
        .wr_data (byte_data.config_byte),
        .cmd     (cmd),
        .stat    (stat)
    );

    aacasc_parse_fsm u_fsm
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_accept (byte_accept),
        .last_byte   (byte_data.last_byte),
        .stat        (stat),
        .out_free    (out_free),
        .byte_stall  (byte_stall),
        .cmd         (cmd),
        .load        (load),
        .result      (result)
    );

    // output register, filled when it is empty or its previous result is being transferred
    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (load)
        begin
            result_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_data_reg <= result;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_data  = result_data_reg;

    assign res_ok     = result_valid && (result_data.status == ST_OK);
    assign res_err    = result_valid && (result_data.status != ST_OK);
    assign err_layout = (result_data.channel_layout == LAYOUT_UNSUP);
    assign err_clear  = (result_data.object_type == 5'd0) && (result_data.sample_rate == 17'd0)
                        && (result_data.extension_rate == 24'd0)
                        && !result_data.sbr_signalled && !result_data.ps_signalled;
    assign type_ok    = (result_data.object_type >= 5'd1) && (result_data.object_type <= 5'd4);
    assign last_in    = byte_accept && byte_data.last_byte;

    `AACASC_ASSERT_IMPLIES(a_err_layout, res_err, err_layout, "error result, layout not 8")
    `AACASC_ASSERT_IMPLIES(a_err_zero, res_err, err_clear, "error result with nonzero fields")
    `AACASC_ASSERT_IMPLIES(a_ok_type, res_ok, type_ok, "ok result with bad object type")
    `AACASC_ASSERT_NEXT(a_last_stalls, last_in, byte_stall, "no stall after last byte")

endmodule

// ===== src/aacasc_bit_reader.sv =====
// ----------------------------------------------------------------------------
// aacasc_bit_reader
// byte store and msb-first serial bit reader, one bit per cycle
// ----------------------------------------------------------------------------
module aacasc_bit_reader
    import aacasc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       wr_en,
    input  logic [7:0] wr_data,
    input  rd_cmd_t    cmd,
    output rd_stat_t   stat
);

    logic [7:0]         mem [MAX_CONFIG_BYTES];
    logic [7:0]         rd_reg;
    logic [7:0]         sh_reg, sh_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [LEN_W-1:0]   left_reg, left_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic               byte_start;
    logic               cur_bit;
    logic [7:0]         src_byte;
    logic [POS_W-1:0]   total;
    logic               store_en;

    // rd_reg always holds the byte at pos_reg, fetched with the next position
    always_comb
    begin
        byte_start = (pos_reg[2:0] == 3'd0);
        src_byte   = byte_start ? rd_reg : sh_reg;
        cur_bit    = src_byte[7];
        store_en   = wr_en && (count_reg < COUNT_MAX);
        total      = {count_reg, 3'b000};

        count_next = count_reg;
        if (cmd.clear_count)
        begin
            count_next = '0;
        end
        else if (store_en)
        begin
            count_next = count_reg + COUNT_W'(1);
        end

        pos_next  = pos_reg;
        left_next = left_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        acc_next  = acc_reg;
        sh_next   = sh_reg;
        if (cmd.start)
        begin
            pos_next  = '0;
            busy_next = 1'b0;
        end
        else if (busy_reg)
        begin
            pos_next  = pos_reg + POS_W'(1);
            acc_next  = {acc_reg[ACC_W-2:0], cur_bit};
            sh_next   = {src_byte[6:0], 1'b0};
            left_next = left_reg - LEN_W'(1);
            if (left_reg == LEN_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (cmd.go)
        begin
            busy_next = 1'b1;
            left_next = cmd.len;
            acc_next  = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_en)
        begin
            mem[count_reg[ADDR_W-1:0]] <= wr_data;
        end
        rd_reg  <= mem[pos_next[ADDR_W+2:3]];
        sh_reg  <= sh_next;
        acc_reg <= acc_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            pos_reg   <= '0;
            left_reg  <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            pos_reg   <= pos_next;
            left_reg  <= left_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    always_comb
    begin
        stat.busy      = busy_reg;
        stat.done      = done_reg;
        stat.value     = acc_reg;
        stat.bits_left = (total > pos_reg) ? (total - pos_reg) : '0;
    end

endmodule

// ===== src/aacasc_parse_fsm.sv =====
// ----------------------------------------------------------------------------
// aacasc_parse_fsm
// sequencer that walks the config fields through the bit reader
// ----------------------------------------------------------------------------
module aacasc_parse_fsm
    import aacasc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      byte_accept,
    input  logic      last_byte,
    input  rd_stat_t  stat,
    input  logic      out_free,
    output logic      byte_stall,
    output rd_cmd_t   cmd,
    output logic      load,
    output out_item_t result
);

    state_t       state_reg, state_next;
    logic         phase_reg, phase_next;
    logic [4:0]   core_type_reg, core_type_next;
    logic [3:0]   rate_idx_reg, rate_idx_next;
    logic [3:0]   chan_reg, chan_next;
    logic [4:0]   ext_type_reg, ext_type_next;
    logic [3:0]   ext_idx_reg, ext_idx_next;
    logic         ext_present_reg, ext_present_next;
    logic [23:0]  ext_explicit_reg, ext_explicit_next;
    logic         ps_reg, ps_next;
    logic [2:0]   status_reg, status_next;
    logic [3:0]   layout_reg, layout_next;
    logic [LEN_W-1:0] len;
    logic         short;
    logic         is_ga;
    logic [ACC_W-1:0] v;

    always_comb
    begin
        len   = field_len(state_reg);
        short = stat.bits_left < {{(POS_W-LEN_W){1'b0}}, len};
        is_ga = (state_reg inside {S_GA_FLEN, S_GA_DEP, S_GA_DELAY, S_GA_EXT, S_GA_EXT3});
        v     = stat.value;
    end

    // next state
    always_comb
    begin
        state_next        = state_reg;
        phase_next        = phase_reg;
        core_type_next    = core_type_reg;
        rate_idx_next     = rate_idx_reg;
        chan_next         = chan_reg;
        ext_type_next     = ext_type_reg;
        ext_idx_next      = ext_idx_reg;
        ext_present_next  = ext_present_reg;
        ext_explicit_next = ext_explicit_reg;
        ps_next           = ps_reg;
        status_next       = status_reg;
        layout_next       = layout_reg;

        case (state_reg)
            S_LOAD:
            begin
                if (byte_accept && last_byte)
                begin
                    state_next = S_START;
                end
            end
            S_START:
            begin
                core_type_next    = '0;
                rate_idx_next     = '0;
                chan_next         = '0;
                ext_type_next     = '0;
                ext_idx_next      = '0;
                ext_present_next  = 1'b0;
                ext_explicit_next = '0;
                ps_next           = 1'b0;
                status_next       = ST_OK;
                layout_next       = '0;
                phase_next        = 1'b0;
                state_next        = S_CORE_TYPE;
            end
            S_CHECK_TYPE:
            begin
                if (!(core_type_reg inside {[5'd1:5'd4]}))
                begin
                    status_next = ST_UNSUP_TYPE;
                    state_next  = S_FINISH;
                end
                else
                begin
                    state_next = S_GA_FLEN;
                end
            end
            S_SYNC_CHECK:
            begin
                if (ext_type_reg != AOT_SBR && stat.bits_left >= SYNC_MIN_BITS)
                begin
                    state_next = S_SYNC_WORD;
                end
                else
                begin
                    state_next = S_EVAL;
                end
            end
            S_PS_CHECK:
            begin
                state_next = (stat.bits_left >= PS_MIN_BITS) ? S_PS_WORD : S_EVAL;
            end
            S_EVAL:
            begin
                state_next = S_FINISH;
                if (rate_idx_reg >= NUM_RATES)
                begin
                    status_next = ST_BAD_FREQ;
                end
                else if (ext_explicit_reg == 24'd0 && ext_present_reg
                         && ext_idx_reg >= NUM_RATES)
                begin
                    status_next = ST_BAD_FREQ;
                end
                else if (ps_reg && chan_reg == LAYOUT_MONO)
                begin
                    layout_next = LAYOUT_STEREO;
                end
                else if (chan_reg >= CHAN_CFG_MAX)
                begin
                    status_next = ST_BAD_CHAN;
                end
                else
                begin
                    layout_next = chan_reg;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = S_LOAD;
                end
            end
            default:
            begin
                // field states: check the bit supply, then wait for the read
                if (!phase_reg)
                begin
                    if (short)
                    begin
                        if (is_ga)
                        begin
                            state_next = S_SYNC_CHECK;
                        end
                        else
                        begin
                            status_next = ST_TRUNCATED;
                            state_next  = S_FINISH;
                        end
                    end
                    else
                    begin
                        phase_next = 1'b1;
                    end
                end
                else if (stat.done)
                begin
                    phase_next = 1'b0;
                    case (state_reg)
                        S_CORE_TYPE:
                        begin
                            core_type_next = v[4:0];
                            state_next     = S_RATE_IDX;
                        end
                        S_RATE_IDX:
                        begin
                            rate_idx_next = v[3:0];
                            state_next    = S_CHAN_CFG;
                        end
                        S_CHAN_CFG:
                        begin
                            chan_next = v[3:0];
                            if (core_type_reg == AOT_SBR || core_type_reg == AOT_PS)
                            begin
                                ps_next       = (core_type_reg == AOT_PS);
                                ext_type_next = AOT_SBR;
                                state_next    = S_EXT_IDX;
                            end
                            else
                            begin
                                state_next = S_CHECK_TYPE;
                            end
                        end
                        S_EXT_IDX:
                        begin
                            ext_idx_next     = v[3:0];
                            ext_present_next = 1'b1;
                            state_next = (v[3:0] == IDX_ESCAPE) ? S_EXT_ESC : S_CORE_TYPE2;
                        end
                        S_EXT_ESC:
                        begin
                            ext_explicit_next = v[23:0];
                            state_next        = S_CORE_TYPE2;
                        end
                        S_CORE_TYPE2:
                        begin
                            core_type_next = v[4:0];
                            state_next     = S_CHECK_TYPE;
                        end
                        S_GA_FLEN:
                        begin
                            state_next = S_GA_DEP;
                        end
                        S_GA_DEP:
                        begin
                            state_next = v[0] ? S_GA_DELAY : S_GA_EXT;
                        end
                        S_GA_DELAY:
                        begin
                            state_next = S_GA_EXT;
                        end
                        S_GA_EXT:
                        begin
                            state_next = v[0] ? S_GA_EXT3 : S_SYNC_CHECK;
                        end
                        S_GA_EXT3:
                        begin
                            state_next = S_SYNC_CHECK;
                        end
                        S_SYNC_WORD:
                        begin
                            state_next = (v[10:0] == SYNC_SBR) ? S_SYNC_TYPE : S_EVAL;
                        end
                        S_SYNC_TYPE:
                        begin
                            ext_type_next = v[4:0];
                            state_next    = (v[4:0] == AOT_SBR) ? S_SBR_FLAG : S_EVAL;
                        end
                        S_SBR_FLAG:
                        begin
                            state_next = v[0] ? S_SYNC_IDX : S_EVAL;
                        end
                        S_SYNC_IDX:
                        begin
                            ext_idx_next     = v[3:0];
                            ext_present_next = 1'b1;
                            state_next = (v[3:0] == IDX_ESCAPE) ? S_SYNC_ESC : S_PS_CHECK;
                        end
                        S_SYNC_ESC:
                        begin
                            ext_explicit_next = v[23:0];
                            state_next        = S_PS_CHECK;
                        end
                        S_PS_WORD:
                        begin
                            state_next = (v[10:0] == SYNC_PS) ? S_PS_FLAG : S_EVAL;
                        end
                        S_PS_FLAG:
                        begin
                            ps_next    = v[0];
                            state_next = S_EVAL;
                        end
                        default:
                        begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end
        endcase
    end

    // outputs
    always_comb
    begin
        byte_stall      = (state_reg != S_LOAD);
        load            = (state_reg == S_FINISH) && out_free;
        cmd.start       = (state_reg == S_START);
        cmd.clear_count = load;
        cmd.go          = (len != LEN_W'(0)) && !phase_reg && !short;
        cmd.len         = len;

        result = '0;
        result.status = status_reg;
        if (status_reg != ST_OK)
        begin
            result.channel_layout = LAYOUT_UNSUP;
        end
        else
        begin
            result.object_type = core_type_reg;
            result.sample_rate = rate_hz(rate_idx_reg);
            if (ext_explicit_reg != 24'd0)
            begin
                result.extension_rate = ext_explicit_reg;
            end
            else if (ext_present_reg)
            begin
                result.extension_rate = {7'd0, rate_hz(ext_idx_reg)};
            end
            result.sbr_signalled  = (ext_type_reg == AOT_SBR);
            result.ps_signalled   = ps_reg;
            result.channel_layout = layout_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_LOAD;
            phase_reg        <= 1'b0;
            core_type_reg    <= '0;
            rate_idx_reg     <= '0;
            chan_reg         <= '0;
            ext_type_reg     <= '0;
            ext_idx_reg      <= '0;
            ext_present_reg  <= 1'b0;
            ext_explicit_reg <= '0;
            ps_reg           <= 1'b0;
            status_reg       <= ST_OK;
            layout_reg       <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            phase_reg        <= phase_next;
            core_type_reg    <= core_type_next;
            rate_idx_reg     <= rate_idx_next;
            chan_reg         <= chan_next;
            ext_type_reg     <= ext_type_next;
            ext_idx_reg      <= ext_idx_next;
            ext_present_reg  <= ext_present_next;
            ext_explicit_reg <= ext_explicit_next;
            ps_reg           <= ps_next;
            status_reg       <= status_next;
            layout_reg       <= layout_next;
        end
    end

endmodule

// ===== bench/tb_aac_audio_specific_config_parser.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_aac_audio_specific_config_parser
// self-checking bench for the audio specific config parser: configs are
// built bit by bit (directed cases, well-formed random configs with random
// content, truncated, overlong and noise byte runs), every accepted byte
// feeds a local parser model, and each result is compared field by field
// ----------------------------------------------------------------------------
module tb_aac_audio_specific_config_parser;
    import aacasc_pkg::*;

    localparam int STUCK_LIMIT  = 20000;
    localparam int DRAIN_CYCLES = 200;

    logic      clk          = 1'b0;
    logic      rst_n        = 1'b0;
    logic      byte_valid   = 1'b0;
    logic      byte_stall;
    in_item_t  byte_data    = '0;
    logic      result_valid;
    logic      result_stall = 1'b0;
    out_item_t result_data;

    // parser model state
    logic [7:0]  asc_bytes [MAX_CONFIG_BYTES];
    int unsigned asc_count = 0;
    int unsigned rd_pos    = 0;
    out_item_t   expected_results [$];

    // config under construction, most significant bit first
    bit bitq [$];

    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int error_count    = 0;
    int bytes_sent     = 0;
    int configs_parsed = 0;
    int results_seen   = 0;
    int stuck_cycles   = 0;
    int status_seen [5] = '{0, 0, 0, 0, 0};

    aac_audio_specific_config_parser i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .byte_data    (byte_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

    always #10 clk = ~clk;

    function automatic logic [16:0] table_hz(input logic [3:0] idx);
        logic [16:0] hz;
        case (idx)
            4'd0:    hz = 17'd96000;
            4'd1:    hz = 17'd88200;
            4'd2:    hz = 17'd64000;
            4'd3:    hz = 17'd48000;
            4'd4:    hz = 17'd44100;
            4'd5:    hz = 17'd32000;
            4'd6:    hz = 17'd24000;
            4'd7:    hz = 17'd22050;
            4'd8:    hz = 17'd16000;
            4'd9:    hz = 17'd12000;
            4'd10:   hz = 17'd11025;
            4'd11:   hz = 17'd8000;
            4'd12:   hz = 17'd7350;
            default: hz = 17'd0;
        endcase
        return hz;
    endfunction

    function automatic int unsigned bits_remaining();
        int unsigned total;
        total = asc_count * 8;
        return (rd_pos < total) ? total - rd_pos : 0;
    endfunction

    // a short read consumes nothing and fails
    function automatic bit read_field(input int unsigned n, output logic [23:0] v);
        v = '0;
        if (bits_remaining() < n)
            return 1'b0;
        for (int unsigned i = 0; i < n; i++)
        begin
            v = {v[22:0], asc_bytes[rd_pos >> 3][7 - (rd_pos & 7)]};
            rd_pos++;
        end
        return 1'b1;
    endfunction

    function automatic bit read_ext_index(output logic [7:0] idx, inout logic [23:0] esc_hz);
        logic [23:0] v;
        idx = 8'hFF;
        if (!read_field(4, v))
            return 1'b0;
        idx = {4'h0, v[3:0]};
        if (v[3:0] == IDX_ESCAPE)
        begin
            if (!read_field(24, v))
                return 1'b0;
            esc_hz = v;
        end
        return 1'b1;
    endfunction

    // running out of bits here just ends the skip
    function automatic void skip_ga_fields();
        logic [23:0] v;
        logic [23:0] ext;
        if (!read_field(1, v))
            return;
        if (!read_field(1, v))
            return;
        if (v[0])
        begin
            if (!read_field(14, v))
                return;
        end
        if (!read_field(1, ext))
            return;
        if (ext[0])
            void'(read_field(1, v));
    endfunction

    function automatic out_item_t error_result(input logic [2:0] st);
        out_item_t r;
        r                = '0;
        r.status         = st;
        r.channel_layout = LAYOUT_UNSUP;
        return r;
    endfunction

    function automatic out_item_t parse_config();
        out_item_t   r;
        logic [23:0] v;
        logic [4:0]  aot;
        logic [4:0]  ext_aot;
        logic [3:0]  rate_idx;
        logic [3:0]  chan;
        logic [7:0]  ext_idx;
        logic [23:0] esc_hz;
        logic [23:0] ext_hz;
        logic        ps;
        logic [3:0]  layout;
        rd_pos  = 0;
        ext_aot = '0;
        ext_idx = 8'hFF;
        esc_hz  = '0;
        ps      = 1'b0;
        if (!read_field(5, v))
            return error_result(ST_TRUNCATED);
        aot = v[4:0];
        if (!read_field(4, v))
            return error_result(ST_TRUNCATED);
        rate_idx = v[3:0];
        if (!read_field(4, v))
            return error_result(ST_TRUNCATED);
        chan = v[3:0];
        // implicit sbr / ps wrapper around the core type
        if (aot == AOT_SBR || aot == AOT_PS)
        begin
            ps      = (aot == AOT_PS);
            ext_aot = AOT_SBR;
            if (!read_ext_index(ext_idx, esc_hz))
                return error_result(ST_TRUNCATED);
            if (!read_field(5, v))
                return error_result(ST_TRUNCATED);
            aot = v[4:0];
        end
        if (aot == 5'd0 || aot > 5'd4)
            return error_result(ST_UNSUP_TYPE);
        skip_ga_fields();
        // backward-compatible sync extension
        if (ext_aot != AOT_SBR && bits_remaining() >= int'(SYNC_MIN_BITS))
        begin
            void'(read_field(11, v));
            if (v[10:0] == SYNC_SBR)
            begin
                void'(read_field(5, v));
                ext_aot = v[4:0];
                if (ext_aot == AOT_SBR)
                begin
                    if (!read_field(1, v))
                        return error_result(ST_TRUNCATED);
                    if (v[0])
                    begin
                        if (!read_ext_index(ext_idx, esc_hz))
                            return error_result(ST_TRUNCATED);
                        if (bits_remaining() >= int'(PS_MIN_BITS))
                        begin
                            void'(read_field(11, v));
                            if (v[10:0] == SYNC_PS)
                            begin
                                if (!read_field(1, v))
                                    return error_result(ST_TRUNCATED);
                                ps = v[0];
                            end
                        end
                    end
                end
            end
        end
        if (rate_idx >= NUM_RATES)
            return error_result(ST_BAD_FREQ);
        ext_hz = esc_hz;
        if (esc_hz == '0 && ext_idx != 8'hFF)
        begin
            if (ext_idx >= 8'(NUM_RATES))
                return error_result(ST_BAD_FREQ);
            ext_hz = 24'(table_hz(ext_idx[3:0]));
        end
        if (ps && chan == LAYOUT_MONO)
            layout = LAYOUT_STEREO;
        else
        begin
            if (chan >= CHAN_CFG_MAX)
                return error_result(ST_BAD_CHAN);
            layout = chan;
        end
        r.status         = ST_OK;
        r.object_type    = aot;
        r.sample_rate    = table_hz(rate_idx);
        r.extension_rate = ext_hz;
        r.sbr_signalled  = (ext_aot == AOT_SBR);
        r.ps_signalled   = ps;
        r.channel_layout = layout;
        return r;
    endfunction

    task automatic accept_byte(input in_item_t it);
        out_item_t r;
        if (asc_count < MAX_CONFIG_BYTES)
        begin
            asc_bytes[asc_count] = it.config_byte;
            asc_count++;
        end
        if (it.last_byte)
        begin
            r = parse_config();
            expected_results.push_back(r);
            status_seen[r.status]++;
            configs_parsed++;
            asc_count = 0;
        end
    endtask

    task automatic check_field(input string name, input logic [23:0] exp_v,
                               input logic [23:0] act_v);
        if (act_v !== exp_v)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
        end
    endtask

    // input transfers feed the model
    always @(posedge clk)
    begin
        if (rst_n && byte_valid && !byte_stall)
            accept_byte(byte_data);
    end

    always @(posedge clk)
    begin
        out_item_t exp_r;
        if (rst_n && result_valid && !result_stall)
        begin
            results_seen++;
            if (expected_results.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected result, expected none, actual %h", $time, result_data);
            end
            else
            begin
                exp_r = expected_results.pop_front();
                check_field("status", 24'(exp_r.status), 24'(result_data.status));
                check_field("object_type", 24'(exp_r.object_type),
                            24'(result_data.object_type));
                check_field("sample_rate", 24'(exp_r.sample_rate),
                            24'(result_data.sample_rate));
                check_field("extension_rate", exp_r.extension_rate,
                            result_data.extension_rate);
                check_field("sbr_signalled", 24'(exp_r.sbr_signalled),
                            24'(result_data.sbr_signalled));
                check_field("ps_signalled", 24'(exp_r.ps_signalled),
                            24'(result_data.ps_signalled));
                check_field("channel_layout", 24'(exp_r.channel_layout),
                            24'(result_data.channel_layout));
            end
        end
    end

    always @(posedge clk)
        result_stall <= ($urandom_range(99) < recv_idle_pct);

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (!rst_n || (byte_valid && !byte_stall) || (result_valid && !result_stall))
            stuck_cycles <= 0;
        else if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("aac_audio_specific_config_parser test failed");
            $finish;
        end
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    task automatic send_byte(input logic [7:0] b, input logic fin);
        while ($urandom_range(99) < send_idle_pct)
        begin
            byte_valid <= 1'b0;
            @(posedge clk);
        end
        byte_valid            <= 1'b1;
        byte_data.config_byte <= b;
        byte_data.last_byte   <= fin;
        @(posedge clk);
        while (byte_stall)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic put_bits(input logic [23:0] v, input int n);
        for (int i = n - 1; i >= 0; i--)
            bitq.push_back(v[i]);
    endtask

    // bits beyond the built config are random padding
    task automatic send_stream(input int nbytes);
        logic [7:0] b;
        int         idx;
        for (int k = 0; k < nbytes; k++)
        begin
            for (int j = 0; j < 8; j++)
            begin
                idx      = k * 8 + j;
                b[7 - j] = (idx < bitq.size()) ? bitq[idx] : 1'($urandom_range(1));
            end
            send_byte(b, k == nbytes - 1);
        end
        bitq.delete();
    endtask

    function automatic logic [3:0] pick_rate_index();
        return ($urandom_range(99) < 88) ? 4'($urandom_range(12)) : 4'($urandom_range(15));
    endfunction

    task automatic put_ext_index();
        if ($urandom_range(99) < 30)
        begin
            put_bits(24'(IDX_ESCAPE), 4);
            case ($urandom_range(3))
                0:       put_bits(24'h0, 24);
                1:       put_bits(24'hFFFFFF, 24);
                default: put_bits(24'($urandom), 24);
            endcase
        end
        else
            put_bits(24'(pick_rate_index()), 4);
    endtask

    task automatic build_wellformed_config(output int nbytes);
        int         pick;
        int         base;
        logic [4:0] aot;
        logic       flag;
        pick = $urandom_range(99);
        if (pick < 55)
            aot = 5'($urandom_range(1, 4));
        else if (pick < 72)
            aot = AOT_SBR;
        else if (pick < 88)
            aot = AOT_PS;
        else
            aot = 5'($urandom_range(31));
        put_bits(24'(aot), 5);
        put_bits(24'(pick_rate_index()), 4);
        put_bits(24'(($urandom_range(99) < 90) ? $urandom_range(7) : $urandom_range(15)), 4);
        if (aot == AOT_SBR || aot == AOT_PS)
        begin
            put_ext_index();
            put_bits(24'(($urandom_range(99) < 90) ? $urandom_range(1, 4)
                                                   : $urandom_range(31)), 5);
        end
        // ga specific config
        put_bits(24'($urandom_range(1)), 1);
        flag = 1'($urandom_range(1));
        put_bits(24'(flag), 1);
        if (flag)
            put_bits(24'($urandom_range(16383)), 14);
        flag = 1'($urandom_range(1));
        put_bits(24'(flag), 1);
        if (flag)
            put_bits(24'($urandom_range(1)), 1);
        if (aot != AOT_SBR && aot != AOT_PS && $urandom_range(99) < 65)
        begin
            put_bits(24'(($urandom_range(99) < 90) ? SYNC_SBR : 11'($urandom_range(2047))), 11);
            put_bits(24'(($urandom_range(99) < 85) ? AOT_SBR : 5'($urandom_range(31))), 5);
            put_bits(24'($urandom_range(99) < 80), 1);
            put_ext_index();
            if ($urandom_range(99) < 70)
            begin
                put_bits(24'(($urandom_range(99) < 90) ? SYNC_PS
                                                       : 11'($urandom_range(2047))), 11);
                put_bits(24'($urandom_range(1)), 1);
            end
        end
        base = (bitq.size() + 7) / 8;
        pick = $urandom_range(99);
        if (pick < 72)
            nbytes = base + $urandom_range(1);
        else if (pick < 88)
            nbytes = $urandom_range(1, base);
        else
            nbytes = $urandom_range(base, MAX_CONFIG_BYTES + 4);
    endtask

    task automatic test_directed_configs();
        // single byte: truncated
        put_bits(24'(8'hFF), 8);
        send_stream(1);
        // lc, 44.1 khz, stereo
        put_bits(2, 5); put_bits(4, 4); put_bits(2, 4); put_bits(0, 3);
        send_stream(2);
        // object type zero
        put_bits(0, 16);
        send_stream(2);
        // escape core frequency index
        put_bits(2, 5); put_bits(24'(IDX_ESCAPE), 4); put_bits(2, 4); put_bits(0, 3);
        send_stream(2);
        // top table entry and channel config fifteen
        put_bits(4, 5); put_bits(12, 4); put_bits(15, 4); put_bits(0, 3);
        send_stream(2);
        // implicit ps, mono, widest escaped frequency, full ga fields
        put_bits(24'(AOT_PS), 5); put_bits(3, 4); put_bits(24'(LAYOUT_MONO), 4);
        put_bits(24'(IDX_ESCAPE), 4); put_bits(24'hFFFFFF, 24); put_bits(2, 5);
        put_bits(0, 1); put_bits(1, 1); put_bits(24'(14'h3FFF), 14);
        put_bits(1, 1); put_bits(1, 1);
        send_stream(8);
        // explicit sbr and ps through the sync extension
        put_bits(1, 5); put_bits(0, 4); put_bits(24'(LAYOUT_MONO), 4); put_bits(0, 3);
        put_bits(24'(SYNC_SBR), 11); put_bits(24'(AOT_SBR), 5); put_bits(1, 1);
        put_bits(8, 4);
        put_bits(24'(SYNC_PS), 11); put_bits(1, 1);
        send_stream(7);
    endtask

    task automatic test_wellformed_configs(input int byte_budget);
        int start;
        int nbytes;
        start = bytes_sent;
        while (bytes_sent - start < byte_budget)
        begin
            build_wellformed_config(nbytes);
            send_stream(nbytes);
        end
    endtask

    // random byte runs, some longer than the store
    task automatic test_noise_configs(input int byte_budget);
        int start;
        int nbytes;
        start = bytes_sent;
        while (bytes_sent - start < byte_budget)
        begin
            nbytes = ($urandom_range(99) < 80) ? $urandom_range(1, 6)
                                               : $urandom_range(7, MAX_CONFIG_BYTES + 4);
            for (int k = 0; k < nbytes; k++)
                put_bits(24'($urandom_range(255)), 8);
            send_stream(nbytes);
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 30;
        recv_idle_pct = 49;
        test_directed_configs();
        test_wellformed_configs(420);
        test_noise_configs(80);

        send_idle_pct = 49;
        recv_idle_pct = 30;
        test_wellformed_configs(300);
        test_noise_configs(100);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_wellformed_configs(280);
        test_noise_configs(80);

        byte_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d configs from %0d bytes, %0d results checked, %0d mismatches",
                 configs_parsed, bytes_sent, results_seen, error_count);
        $display("status mix: ok %0d, truncated %0d, bad type %0d, bad rate %0d, bad chan %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4]);
        if (error_count == 0)
            $display("aac_audio_specific_config_parser test passed");
        else
            $display("aac_audio_specific_config_parser test failed");
        $finish;
    end

endmodule
